// File: design/tli_pkg.sv
// Shared types and constants for the table linear interpolator.
// Holds the FSM state type, the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package tli_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 9;
    localparam int DATA_W      = 32;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int DIV_CNT_W   = $clog2(PROD_W);

    localparam logic [CNT_W-1:0]     MIN_POINTS = CNT_W'(2);
    localparam logic [CNT_W-1:0]     MAX_POINTS = CNT_W'(TABLE_DEPTH);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST   = DIV_CNT_W'(PROD_W - 1);

    // Item function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK_FIRST,
        S_CHK_LAST,
        S_WALK,
        S_RD_LO,
        S_RD_HI,
        S_DIFF,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        A_ZERO,
        A_ONE,
        A_LAST,
        A_KNEXT,
        A_M,
        A_M1
    } t_addr_sel;

    typedef enum logic [1:0] {
        M_ZERO,
        M_LASTM1,
        M_KM1
    } t_m_sel;

    typedef struct packed {
        logic      load;
        logic      query_start;
        logic      rd_en;
        t_addr_sel addr_sel;
        logic      k_init;
        logic      k_inc;
        logic      m_set;
        t_m_sel    m_sel;
        logic      cap_lo;
        logic      diff;
        logic      mul;
        logic      div_step;
        logic      out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic q_le_rd;
        logic q_ge_rd;
        logic k_lt_last;
        logic zero_span;
        logic div_last;
        logic out_free;
    } t_dp_stat;

endpackage

// File: design/tli_ctrl.sv
// Controller FSM for the table linear interpolator.
// Sequences table search, segment fetch, multiply and serial divide.
// Depends on tli_pkg.
`timescale 1ns / 1ps

module tli_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_func,
    input  tli_pkg::t_dp_stat i_stat,
    output tli_pkg::t_dp_cmd  o_cmd,
    output logic             o_in_stall
);

    tli_pkg::t_state r_state;
    tli_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tli_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tli_pkg::S_IDLE: begin
                if (i_in_valid && i_func == tli_pkg::FUNC_QUERY) begin
                    n_state = tli_pkg::S_CHK_FIRST;
                end
            end
            tli_pkg::S_CHK_FIRST: begin
                n_state = i_stat.q_le_rd ? tli_pkg::S_RD_LO : tli_pkg::S_CHK_LAST;
            end
            tli_pkg::S_CHK_LAST: begin
                n_state = i_stat.q_ge_rd ? tli_pkg::S_RD_LO : tli_pkg::S_WALK;
            end
            tli_pkg::S_WALK: begin
                if (!(i_stat.k_lt_last && i_stat.q_ge_rd)) begin
                    n_state = tli_pkg::S_RD_LO;
                end
            end
            tli_pkg::S_RD_LO: n_state = tli_pkg::S_RD_HI;
            tli_pkg::S_RD_HI: n_state = tli_pkg::S_DIFF;
            tli_pkg::S_DIFF:  n_state = tli_pkg::S_MUL;
            tli_pkg::S_MUL: begin
                n_state = i_stat.zero_span ? tli_pkg::S_OUT : tli_pkg::S_DIV;
            end
            tli_pkg::S_DIV: begin
                if (i_stat.div_last) begin
                    n_state = tli_pkg::S_OUT;
                end
            end
            tli_pkg::S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = tli_pkg::S_IDLE;
                end
            end
            default: n_state = tli_pkg::S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.addr_sel = tli_pkg::A_ZERO;
        o_cmd.m_sel    = tli_pkg::M_ZERO;
        o_in_stall     = 1'b1;
        case (r_state)
            tli_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_func == tli_pkg::FUNC_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.query_start = 1'b1;
                        o_cmd.rd_en       = 1'b1;
                        o_cmd.addr_sel    = tli_pkg::A_ZERO;
                    end
                end
            end
            tli_pkg::S_CHK_FIRST: begin
                if (i_stat.q_le_rd) begin
                    o_cmd.m_set = 1'b1;
                    o_cmd.m_sel = tli_pkg::M_ZERO;
                end else begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.addr_sel = tli_pkg::A_LAST;
                end
            end
            tli_pkg::S_CHK_LAST: begin
                if (i_stat.q_ge_rd) begin
                    o_cmd.m_set = 1'b1;
                    o_cmd.m_sel = tli_pkg::M_LASTM1;
                end else begin
                    o_cmd.k_init   = 1'b1;
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.addr_sel = tli_pkg::A_ONE;
                end
            end
            tli_pkg::S_WALK: begin
                if (i_stat.k_lt_last && i_stat.q_ge_rd) begin
                    o_cmd.k_inc    = 1'b1;
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.addr_sel = tli_pkg::A_KNEXT;
                end else begin
                    o_cmd.m_set = 1'b1;
                    o_cmd.m_sel = tli_pkg::M_KM1;
                end
            end
            tli_pkg::S_RD_LO: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.addr_sel = tli_pkg::A_M;
            end
            tli_pkg::S_RD_HI: begin
                o_cmd.cap_lo   = 1'b1;
                o_cmd.rd_en    = 1'b1;
                o_cmd.addr_sel = tli_pkg::A_M1;
            end
            tli_pkg::S_DIFF: o_cmd.diff     = 1'b1;
            tli_pkg::S_MUL:  o_cmd.mul      = 1'b1;
            tli_pkg::S_DIV:  o_cmd.div_step = 1'b1;
            tli_pkg::S_OUT: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

// File: design/tli_dp.sv
// Datapath for the table linear interpolator: breakpoint tables, search
// counter, segment differences, multiplier, restoring divider, output register.
// Depends on tli_pkg.
`timescale 1ns / 1ps

module tli_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tli_pkg::CNT_W-1:0]   i_cfg_data,
    input  tli_pkg::t_dp_cmd            i_cmd,
    output tli_pkg::t_dp_stat           o_stat,
    input  logic [7:0]                  i_entry_index,
    input  logic [31:0]                 i_entry_position,
    input  logic [31:0]                 i_entry_value,
    input  logic [31:0]                 i_query_position,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [31:0]                 o_interp_value,
    output logic                        o_zero_span,
    output logic                        o_saturated
);

    localparam int AW = tli_pkg::ADDR_W;
    localparam int DW = tli_pkg::DATA_W;
    localparam int PW = tli_pkg::PROD_W;

    // Breakpoint memories
    logic [DW-1:0] pos_mem [tli_pkg::TABLE_DEPTH];
    logic [DW-1:0] val_mem [tli_pkg::TABLE_DEPTH];

    logic [tli_pkg::CNT_W-1:0] r_point_count;
    logic [tli_pkg::CNT_W-1:0] n_eff;
    logic [tli_pkg::CNT_W-1:0] n_last_w;
    logic [AW-1:0]             last_idx;

    logic [DW-1:0] r_q;
    logic [DW-1:0] r_rd_pos;
    logic [DW-1:0] r_rd_val;
    logic [AW-1:0] r_k;
    logic [AW-1:0] r_m;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] r_p0;
    logic [DW-1:0] r_v0;

    logic [DW:0]   dp_w;
    logic [DW:0]   dv_w;
    logic [DW:0]   dx_w;
    logic [DW:0]   dp_neg;
    logic [DW:0]   dv_neg;
    logic [DW:0]   dx_neg;
    logic [DW-1:0] r_mag_dv;
    logic [DW-1:0] r_mag_dx;
    logic [DW-1:0] r_divisor;
    logic          r_neg;
    logic          r_zero;

    logic [PW-1:0]                 r_quot;
    logic [DW-1:0]                 r_rem;
    logic [tli_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [DW:0]                   shifted;
    logic [DW:0]                   trial;
    logic                          q_bit;

    logic          big;
    logic [DW+2:0] q_ext;
    logic [DW+2:0] sum_w;
    logic [DW-1:0] res_value;
    logic          res_sat;

    logic          r_out_valid;
    logic          n_out_valid;
    logic [DW-1:0] r_out_value;
    logic          r_out_zero;
    logic          r_out_sat;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= tli_pkg::MIN_POINTS;
        end else if (i_cfg_we) begin
            r_point_count <= i_cfg_data;
        end
    end

    // Clamp the point count to the table range
    always_comb begin
        if (r_point_count < tli_pkg::MIN_POINTS) begin
            n_eff = tli_pkg::MIN_POINTS;
        end else if (r_point_count > tli_pkg::MAX_POINTS) begin
            n_eff = tli_pkg::MAX_POINTS;
        end else begin
            n_eff = r_point_count;
        end
        n_last_w = n_eff - tli_pkg::CNT_W'(1);
        last_idx = n_last_w[AW-1:0];
    end

    // Read address select
    always_comb begin
        case (i_cmd.addr_sel)
            tli_pkg::A_ZERO:  rd_addr = '0;
            tli_pkg::A_ONE:   rd_addr = AW'(1);
            tli_pkg::A_LAST:  rd_addr = last_idx;
            tli_pkg::A_KNEXT: rd_addr = r_k + AW'(1);
            tli_pkg::A_M:     rd_addr = r_m;
            tli_pkg::A_M1:    rd_addr = r_m + AW'(1);
            default:          rd_addr = '0;
        endcase
    end

    // Table write on load beats, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            pos_mem[i_entry_index[AW-1:0]] <= i_entry_position;
        end
        if (i_cmd.rd_en) begin
            r_rd_pos <= pos_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            val_mem[i_entry_index[AW-1:0]] <= i_entry_value;
        end
        if (i_cmd.rd_en) begin
            r_rd_val <= val_mem[rd_addr];
        end
    end

    // Query, search counter and segment index
    always_ff @(posedge i_clk) begin
        if (i_cmd.query_start) begin
            r_q <= i_query_position;
        end
        if (i_cmd.k_init) begin
            r_k <= AW'(1);
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + AW'(1);
        end
        if (i_cmd.m_set) begin
            case (i_cmd.m_sel)
                tli_pkg::M_ZERO:   r_m <= '0;
                tli_pkg::M_LASTM1: r_m <= last_idx - AW'(1);
                tli_pkg::M_KM1:    r_m <= r_k - AW'(1);
                default:           r_m <= '0;
            endcase
        end
        if (i_cmd.cap_lo) begin
            r_p0 <= r_rd_pos;
            r_v0 <= r_rd_val;
        end
    end

    // Segment differences and their magnitudes
    always_comb begin
        dp_w   = {r_rd_pos[DW-1], r_rd_pos} - {r_p0[DW-1], r_p0};
        dv_w   = {r_rd_val[DW-1], r_rd_val} - {r_v0[DW-1], r_v0};
        dx_w   = {r_q[DW-1], r_q} - {r_p0[DW-1], r_p0};
        dp_neg = -dp_w;
        dv_neg = -dv_w;
        dx_neg = -dx_w;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            r_divisor <= dp_w[DW] ? dp_neg[DW-1:0] : dp_w[DW-1:0];
            r_mag_dv  <= dv_w[DW] ? dv_neg[DW-1:0] : dv_w[DW-1:0];
            r_mag_dx  <= dx_w[DW] ? dx_neg[DW-1:0] : dx_w[DW-1:0];
            r_neg     <= dp_w[DW] ^ dv_w[DW] ^ dx_w[DW];
            r_zero    <= (dp_w == '0);
        end
    end

    // Restoring divider step: one quotient bit per cycle
    always_comb begin
        shifted = {r_rem, r_quot[PW-1]};
        trial   = shifted - {1'b0, r_divisor};
        q_bit   = (shifted >= {1'b0, r_divisor});
    end

    // Product loads the dividend; the divider shifts the quotient in behind it
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_quot    <= PW'(r_mag_dv) * PW'(r_mag_dx);
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quot    <= {r_quot[PW-2:0], q_bit};
            r_rem     <= q_bit ? trial[DW-1:0] : shifted[DW-1:0];
            r_div_cnt <= r_div_cnt + tli_pkg::DIV_CNT_W'(1);
        end
    end

    // Apply sign, add the left value and saturate
    always_comb begin
        big   = (|r_quot[PW-1:DW+2]) || (r_quot[DW+1] && (|r_quot[DW:0]));
        q_ext = {1'b0, r_quot[DW+1:0]};
        sum_w = {{3{r_v0[DW-1]}}, r_v0} + (r_neg ? -q_ext : q_ext);
        res_sat = 1'b0;
        if (r_zero) begin
            res_value = '0;
        end else if (big) begin
            res_sat   = 1'b1;
            res_value = r_neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else if (sum_w[DW+2] && !(&sum_w[DW+1:DW-1])) begin
            res_sat   = 1'b1;
            res_value = {1'b1, {(DW-1){1'b0}}};
        end else if (!sum_w[DW+2] && (|sum_w[DW+1:DW-1])) begin
            res_sat   = 1'b1;
            res_value = {1'b0, {(DW-1){1'b1}}};
        end else begin
            res_value = sum_w[DW-1:0];
        end
    end

    // Output register: hold while the receiver stalls
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value <= res_value;
            r_out_zero  <= r_zero;
            r_out_sat   <= res_sat;
        end
    end

    // Status back to the controller
    always_comb begin
        o_stat.q_le_rd   = ($signed(r_q) <= $signed(r_rd_pos));
        o_stat.q_ge_rd   = ($signed(r_q) >= $signed(r_rd_pos));
        o_stat.k_lt_last = (r_k < last_idx);
        o_stat.zero_span = r_zero;
        o_stat.div_last  = (r_div_cnt == tli_pkg::DIV_LAST);
        o_stat.out_free  = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid    = r_out_valid;
    assign o_interp_value = r_out_value;
    assign o_zero_span    = r_out_zero;
    assign o_saturated    = r_out_sat;

endmodule

// File: design/table_linear_interpolator.sv
// Piecewise linear interpolator over a 256-entry breakpoint table.
//
// Input channel (i_in_valid / o_in_stall): a beat with i_func = 0 writes one
// breakpoint (position, value) into slot i_entry_index and gives no result.
// A beat with i_func = 1 queries the table at i_query_position.
// Output channel (o_out_valid / i_out_stall): one beat per query carrying the
// saturated Q16.16 result and the zero_span and saturated flags.
// Config: i_cfg_we writes i_cfg_data into point_count; write only when idle.
// A query compares against the first and last breakpoints, walks table entries
// in the segment search when it lies between them, one per cycle through the
// single memory read port, then reads the segment ends, forms the differences and
// product, and runs a bit-serial restoring divide unless the span is zero.
// One item is in work at a time; o_in_stall is low only while idle.
// A finished result sits in the output register while the next item is taken;
// if the receiver stalls, a later result waits in the controller until the
// register frees up. Reset clears control state and sets point_count to 2;
// table contents are undefined until written.
// Depends on tli_pkg, tli_ctrl, tli_dp.
`timescale 1ns / 1ps

module table_linear_interpolator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [7:0]  i_entry_index,
    input  logic [31:0] i_entry_position,
    input  logic [31:0] i_entry_value,
    input  logic [31:0] i_query_position,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_interp_value,
    output logic        o_zero_span,
    output logic        o_saturated
);

    tli_pkg::t_dp_cmd  cmd;
    tli_pkg::t_dp_stat stat;

    // Sequencer
    tli_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Tables and arithmetic
    tli_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_entry_index    (i_entry_index),
        .i_entry_position (i_entry_position),
        .i_entry_value    (i_entry_value),
        .i_query_position (i_query_position),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_interp_value   (o_interp_value),
        .o_zero_span      (o_zero_span),
        .o_saturated      (o_saturated)
    );

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for table_linear_interpolator: loads breakpoint tables,
// sweeps point_count and queries positions under random idling and back-pressure.
// Depends on tli_pkg and the table_linear_interpolator RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int     LOAD_DRAIN = 20;
    localparam int     END_DRAIN  = 60;
    localparam longint SAT_HI     = 64'sd2147483647;
    localparam longint SAT_LO     = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] value;
        logic        zero_span;
        logic        saturated;
    } t_interp;

    // DUT connections
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [8:0]  cfg_data    = '0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic        func        = tli_pkg::FUNC_LOAD;
    logic [7:0]  entry_index = '0;
    logic [31:0] entry_pos   = '0;
    logic [31:0] entry_val   = '0;
    logic [31:0] query_pos   = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [31:0] out_interp;
    logic        out_zero_span;
    logic        out_saturated;

    // Predictor state: breakpoint tables and point_count as the block holds them
    logic signed [31:0] brk_pos [tli_pkg::TABLE_DEPTH];
    logic signed [31:0] brk_val [tli_pkg::TABLE_DEPTH];
    logic [8:0]         cfg_point_count = tli_pkg::MIN_POINTS;
    t_interp            expected_interp [$];
    t_interp            head_interp;

    int err_count         = 0;
    bit no_idle           = 1'b0;
    int hold_request      = 0;
    int stall_cycles_left = 0;
    int stall_roll;

    table_linear_interpolator dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_func           (func),
        .i_entry_index    (entry_index),
        .i_entry_position (entry_pos),
        .i_entry_value    (entry_val),
        .i_query_position (query_pos),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_interp_value   (out_interp),
        .o_zero_span      (out_zero_span),
        .o_saturated      (out_saturated)
    );

    // 12 ns clock
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned effective_count();
        if (cfg_point_count < tli_pkg::MIN_POINTS) return tli_pkg::MIN_POINTS;
        if (cfg_point_count > tli_pkg::MAX_POINTS) return tli_pkg::MAX_POINTS;
        return cfg_point_count;
    endfunction

    function automatic logic [63:0] abs64(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Segment search, exact quotient truncated toward zero, then saturation
    function automatic t_interp predict_interp(logic signed [31:0] q);
        int unsigned        n, m, k;
        logic signed [31:0] p0, p1, v0, v1;
        longint             dp, dv, dx, sum;
        logic [63:0]        quot;
        logic               neg;
        t_interp            res;
        n = effective_count();
        if (q <= brk_pos[0]) begin
            m = 0;
        end else if (q >= brk_pos[n - 1]) begin
            m = n - 2;
        end else begin
            k = 1;
            while (k < n - 1 && brk_pos[k] <= q) k++;
            m = k - 1;
        end
        p0  = brk_pos[m];
        p1  = brk_pos[m + 1];
        v0  = brk_val[m];
        v1  = brk_val[m + 1];
        dp  = longint'(p1) - longint'(p0);
        res = '0;
        if (dp == 0) begin
            res.zero_span = 1'b1;
        end else begin
            dv   = longint'(v1) - longint'(v0);
            dx   = longint'(q) - longint'(p0);
            quot = (abs64(dv) * abs64(dx)) / abs64(dp);
            neg  = ((dv < 0) != (dx < 0)) != (dp < 0);
            if (quot > 64'h2_0000_0000) begin
                res.saturated = 1'b1;
                res.value     = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                sum = neg ? longint'(v0) - longint'(quot) : longint'(v0) + longint'(quot);
                if (sum > SAT_HI) begin
                    sum           = SAT_HI;
                    res.saturated = 1'b1;
                end else if (sum < SAT_LO) begin
                    sum           = SAT_LO;
                    res.saturated = 1'b1;
                end
                res.value = sum[31:0];
            end
        end
        return res;
    endfunction

    // Mostly back-to-back beats, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        if (no_idle) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] random_value(bit wide);
        if (wide) return $urandom;
        return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endfunction

    // Query inside a segment, at or next to a breakpoint, or anywhere
    function automatic logic [31:0] pick_query(int unsigned eff);
        int unsigned roll, seg;
        longint      lo, hi;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            seg = $urandom_range(0, eff - 2);
            lo  = brk_pos[seg];
            hi  = brk_pos[seg + 1];
            if (hi < lo) begin
                lo = brk_pos[seg + 1];
                hi = brk_pos[seg];
            end
            return 32'(lo + longint'($urandom_range(0, 32'(hi - lo))));
        end
        if (roll < 80)
            return brk_pos[$urandom_range(0, eff - 1)] + 32'($urandom_range(0, 2)) - 32'd1;
        return $urandom;
    endfunction

    // Offer one beat, hold it until accepted, then update the prediction
    task automatic send_beat(logic f, logic [7:0] idx, logic [31:0] pos, logic [31:0] val,
                             logic [31:0] qpos);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= f;
        entry_index <= idx;
        entry_pos   <= pos;
        entry_val   <= val;
        query_pos   <= qpos;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (f == tli_pkg::FUNC_LOAD) begin
            brk_pos[idx] = pos;
            brk_val[idx] = val;
        end else begin
            expected_interp.push_back(predict_interp(qpos));
        end
    endtask

    task automatic load_entry(logic [7:0] idx, logic [31:0] pos, logic [31:0] val);
        send_beat(tli_pkg::FUNC_LOAD, idx, pos, val, $urandom);
    endtask

    task automatic query_at(logic [31:0] qpos);
        send_beat(tli_pkg::FUNC_QUERY, 8'($urandom), $urandom, $urandom, qpos);
    endtask

    // Drain all results, then allow a trailing load to finish
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_interp.size() != 0) @(posedge clk);
        repeat (LOAD_DRAIN) @(posedge clk);
    endtask

    task automatic write_point_count(logic [8:0] count);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= count;
        @(posedge clk);
        cfg_we          <= 1'b0;
        cfg_point_count  = count;
    endtask

    // Ascending positions with random steps; zero steps give flat segments
    task automatic load_ascending_table(int unsigned eff, bit wide);
        longint      span, step, pos;
        int unsigned i;
        case ($urandom_range(0, 2))
            0: span = (eff - 1) * $urandom_range(1, 4);
            1: span = (eff - 1) * $urandom_range(32'h100, 32'h4_0000);
            default: span = 64'hFFFF_FFFF;
        endcase
        step = span / (eff - 1);
        pos  = longint'($urandom_range(0, 32'(64'hFFFF_FFFF - span))) - 64'sd2147483648;
        for (i = 0; i < eff; i++) begin
            load_entry(8'(i), 32'(pos), random_value(wide));
            pos += longint'($urandom_range(0, 32'(step)));
        end
    endtask

    // Reset point_count of two: interpolation and extrapolation on both sides
    task automatic test_two_point_segment();
        load_entry(8'd0, 32'h0000_0000, 32'h0000_0000);
        load_entry(8'd1, 32'h0001_0000, 32'h0002_0000);
        query_at(32'h0000_8000);
        query_at(32'h0000_0000);
        query_at(32'h0001_0000);
        query_at(32'hFFFF_0000);
        query_at(32'h0003_0000);
    endtask

    task automatic test_extreme_breakpoints();
        load_entry(8'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        load_entry(8'd1, 32'h7FFF_FFFF, 32'h8000_0000);
        query_at(32'h8000_0000);
        query_at(32'h7FFF_FFFF);
        query_at(32'h0000_0000);
    endtask

    // Clip both on a huge quotient and on the final sum
    task automatic test_saturation();
        load_entry(8'd0, 32'h0000_0000, 32'h0000_0000);
        load_entry(8'd1, 32'h0000_0001, 32'h7FFF_FFFF);
        query_at(32'h7FFF_FFFF);
        query_at(32'h8000_0000);
        query_at(32'h0000_0002);
    endtask

    task automatic test_zero_span();
        load_entry(8'd0, 32'h0005_0000, 32'h0000_1234);
        load_entry(8'd1, 32'h0005_0000, 32'h0000_5678);
        query_at(32'h0005_0000);
        query_at(32'h8000_0000);
    endtask

    // Counts below two act as two; then a table that is not ascending
    task automatic test_point_count_clamp();
        load_entry(8'd1, 32'h0002_0000, 32'hFFFF_0000);
        write_point_count(9'd0);
        query_at(32'h0004_0000);
        write_point_count(9'd1);
        query_at(32'h0000_8000);
        write_point_count(9'd3);
        load_entry(8'd0, 32'h0003_0000, 32'h0000_0001);
        load_entry(8'd1, 32'h0001_0000, 32'h0000_0002);
        load_entry(8'd2, 32'h0002_0000, 32'h0000_0003);
        query_at(32'h0002_8000);
        query_at(32'h0000_8000);
    endtask

    // Hold the output for a long stretch while beats keep coming
    task automatic test_output_backpressure();
        wait_idle();
        no_idle      = 1'b1;
        hold_request = 500;
        repeat (8) query_at(pick_query(effective_count()));
        no_idle = 1'b0;
    endtask

    task automatic test_random_tables();
        int unsigned counts [10] = '{2, 3, 5, 8, 2, 16, 40, 256, 511, 300};
        int unsigned eff, roll;
        bit          wide, full_loaded;
        full_loaded = 1'b0;
        foreach (counts[p]) begin
            write_point_count(9'(counts[p]));
            no_idle = ($urandom_range(0, 3) == 0);
            eff     = effective_count();
            wide    = $urandom_range(0, 1);
            if (eff < tli_pkg::TABLE_DEPTH || !full_loaded) begin
                load_ascending_table(eff, wide);
                if (eff == tli_pkg::TABLE_DEPTH) full_loaded = 1'b1;
            end
            repeat (30) begin
                roll = $urandom_range(0, 99);
                if (roll < 85)
                    query_at(pick_query(eff));
                else if (roll < 93)
                    load_entry(8'($urandom_range(0, eff - 1)), $urandom, random_value(wide));
                else
                    load_entry(8'($urandom), $urandom, random_value(wide));
            end
        end
        no_idle = 1'b0;
    endtask

    // Random output stalls, plus long holds on request
    always @(posedge clk) begin
        if (hold_request > 0) begin
            stall_cycles_left = hold_request;
            hold_request      = 0;
        end
        if (stall_cycles_left > 0) begin
            out_stall <= 1'b1;
            stall_cycles_left--;
        end else if (no_idle) begin
            out_stall <= 1'b0;
        end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 80) begin
                out_stall <= 1'b0;
            end else begin
                out_stall         <= 1'b1;
                stall_cycles_left  = (stall_roll < 97) ? $urandom_range(0, 2)
                                                       : $urandom_range(10, 50);
            end
        end
    end

    // Compare each accepted result beat with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (expected_interp.size() == 0) begin
                $display("%0t: unexpected result beat, actual value %h zero_span %b saturated %b",
                         $time, out_interp, out_zero_span, out_saturated);
                err_count++;
            end else begin
                head_interp = expected_interp.pop_front();
                if (out_interp !== head_interp.value) begin
                    $display("%0t: interp_value expected %h actual %h",
                             $time, head_interp.value, out_interp);
                    err_count++;
                end
                if (out_zero_span !== head_interp.zero_span) begin
                    $display("%0t: zero_span expected %b actual %b",
                             $time, head_interp.zero_span, out_zero_span);
                    err_count++;
                end
                if (out_saturated !== head_interp.saturated) begin
                    $display("%0t: saturated expected %b actual %b",
                             $time, head_interp.saturated, out_saturated);
                    err_count++;
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_two_point_segment();
        test_extreme_breakpoints();
        test_saturation();
        test_zero_span();
        test_point_count_clamp();
        test_output_backpressure();
        test_random_tables();
        wait_idle();
        repeat (END_DRAIN) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #30_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: table_linear_interpolator.f
design/tli_pkg.sv
design/tli_ctrl.sv
design/tli_dp.sv
design/table_linear_interpolator.sv
sim/tb_top.sv
